@@ rtl/fpsac_pkg.sv @@
// ----------------------------------------------------------------------------
// fpsac_pkg
// Shared types for the frame parser with sum and add check.
// ----------------------------------------------------------------------------
package fpsac_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] payload_byte;
    logic [WordW-1:0] payload_index;
    logic [ByteW-1:0] source_address;
    logic [ByteW-1:0] destination_address;
    logic [ByteW-1:0] function_code;
    logic [WordW-1:0] payload_length;
    logic             check_ok;
  } result_t;

endpackage

@@ rtl/frame_parser_sum_add_check.sv @@
// ----------------------------------------------------------------------------
// frame_parser_sum_add_check
// Frame parser: head byte hunt, header capture, payload streaming and an
// 8-bit sum / sum-of-sums check at the end of each frame.
// ----------------------------------------------------------------------------
//  channel | signals                         | beat
//  --------+---------------------------------+--------------------------------
//  in      | in_valid_i / in_ready_o         | data_byte_i
//  out     | out_valid_o / out_ready_i       | kind_o .. check_ok_o
//  config  | head_byte_we_i                  | head_byte_i
//
//  one input beat per cycle while in_ready_o is high; the parser state updates
//  in the accepting cycle and each result is registered in the output buffer.
//  in_ready_o drops only when both output buffer entries are full.
//  reset returns to the hunt with the head byte at 0xab.
// ----------------------------------------------------------------------------
module frame_parser_sum_add_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_byte_we_i,
  input  logic [7:0]  head_byte_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] payload_index_o,
  output logic [7:0]  source_address_o,
  output logic [7:0]  destination_address_o,
  output logic [7:0]  function_code_o,
  output logic [15:0] payload_length_o,
  output logic        check_ok_o
);

  typedef enum logic [3:0] {
    PhHunt, PhSrc, PhDst, PhFunc, PhLen1, PhLen2, PhData, PhSum, PhAdd
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  head_q;
  logic [7:0]  src_q, src_d;
  logic [7:0]  dst_q, dst_d;
  logic [7:0]  func_q, func_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  add_q, add_d;
  logic [7:0]  rx_sum_q, rx_sum_d;

  logic               accept;
  logic               push;
  logic [7:0]         acc_sum;
  logic [7:0]         acc_add;
  logic [7:0]         start_add;
  logic [15:0]        count_inc;
  logic [15:0]        len_full;
  fpsac_pkg::result_t res;
  fpsac_pkg::result_t out_data;

  assign accept    = in_valid_i & in_ready_o;
  assign acc_sum   = sum_q + data_byte_i;
  assign acc_add   = add_q + acc_sum;
  assign start_add = data_byte_i;
  assign count_inc = count_q + 16'd1;
  assign len_full  = {data_byte_i, len_q[7:0]};

  always_comb begin
    phase_d  = phase_q;
    src_d    = src_q;
    dst_d    = dst_q;
    func_d   = func_q;
    len_d    = len_q;
    count_d  = count_q;
    sum_d    = sum_q;
    add_d    = add_q;
    rx_sum_d = rx_sum_q;
    push     = 1'b0;

    res.kind                = fpsac_pkg::KindPayload;
    res.payload_byte        = '0;
    res.payload_index       = '0;
    res.source_address      = src_q;
    res.destination_address = dst_q;
    res.function_code       = func_q;
    res.payload_length      = len_q;
    res.check_ok            = 1'b0;

    case (phase_q)
      PhSrc: begin
        src_d   = data_byte_i;
        sum_d   = acc_sum;
        add_d   = acc_add;
        phase_d = PhDst;
      end
      PhDst: begin
        dst_d   = data_byte_i;
        sum_d   = acc_sum;
        add_d   = acc_add;
        phase_d = PhFunc;
      end
      PhFunc: begin
        func_d  = data_byte_i;
        sum_d   = acc_sum;
        add_d   = acc_add;
        phase_d = PhLen1;
      end
      PhLen1: begin
        len_d   = {8'h00, data_byte_i};
        sum_d   = acc_sum;
        add_d   = acc_add;
        phase_d = PhLen2;
      end
      PhLen2: begin
        len_d   = len_full;
        sum_d   = acc_sum;
        add_d   = acc_add;
        count_d = '0;
        phase_d = (len_full == 16'd0) ? PhSum : PhData;
      end
      PhData: begin
        sum_d             = acc_sum;
        add_d             = acc_add;
        push              = 1'b1;
        res.payload_byte  = data_byte_i;
        res.payload_index = count_q;
        count_d           = count_inc;
        if (count_inc == len_q) begin
          phase_d = PhSum;
        end
      end
      PhSum: begin
        rx_sum_d = data_byte_i;
        phase_d  = PhAdd;
      end
      PhAdd: begin
        push         = 1'b1;
        res.kind     = fpsac_pkg::KindEnd;
        res.check_ok = (rx_sum_q == sum_q) && (data_byte_i == add_q);
        phase_d      = PhHunt;
      end
      default: begin
        if (data_byte_i == head_q) begin
          sum_d   = data_byte_i;
          add_d   = start_add;
          count_d = '0;
          phase_d = PhSrc;
        end else begin
          phase_d = PhHunt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      head_q   <= 8'hab;
      src_q    <= '0;
      dst_q    <= '0;
      func_q   <= '0;
      len_q    <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      add_q    <= '0;
      rx_sum_q <= '0;
    end else begin
      if (head_byte_we_i) begin
        head_q <= head_byte_i;
      end
      if (accept) begin
        phase_q  <= phase_d;
        src_q    <= src_d;
        dst_q    <= dst_d;
        func_q   <= func_d;
        len_q    <= len_d;
        count_q  <= count_d;
        sum_q    <= sum_d;
        add_q    <= add_d;
        rx_sum_q <= rx_sum_d;
      end
    end
  end

  fpsac_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept & push),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o                = out_data.kind;
  assign payload_byte_o        = out_data.payload_byte;
  assign payload_index_o       = out_data.payload_index;
  assign source_address_o      = out_data.source_address;
  assign destination_address_o = out_data.destination_address;
  assign function_code_o       = out_data.function_code;
  assign payload_length_o      = out_data.payload_length;
  assign check_ok_o            = out_data.check_ok;

endmodule

@@ rtl/fpsac_skid.sv @@
// ----------------------------------------------------------------------------
// fpsac_skid
// Two-entry output buffer; ready towards the parser comes from a register.
// ----------------------------------------------------------------------------
module fpsac_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fpsac_pkg::result_t push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fpsac_pkg::result_t out_data_o
);

  fpsac_pkg::result_t main_q;
  fpsac_pkg::result_t skid_q;
  logic               main_valid_q;
  logic               skid_valid_q;
  logic               pop;

  assign pop         = main_valid_q & out_ready_i;
  assign space_o     = ~skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_parser_sum_add_check. A directed list of
// bytes walks the zero-length frame, hunt noise, the old head byte in a frame,
// a head change mid-frame and a failed check. Random phases follow, each with
// its own head byte: mostly well-formed frames with random content, with
// noise, cut-short frames and bad check bytes mixed in. Every result beat is
// checked against an in-bench parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned FrameTarget = 1850;
  localparam int unsigned NumPhases = 6;

  typedef enum logic [3:0] {
    PhHunt, PhSrc, PhDst, PhFunc, PhLen1, PhLen2, PhData, PhSum, PhAdd
  } parse_phase_e;

  typedef struct {
    logic [7:0]         value;
    bit                 head_write;
    bit                 typed;
    fpsac_pkg::result_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic head_we = 1'b0;
  logic [7:0] head_val = 8'h00;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic out_ready = 1'b0;
  bit calm = 1'b0;

  logic in_ready_o, out_valid_o, kind_o, check_ok_o;
  logic [7:0] payload_byte_o, source_address_o, destination_address_o, function_code_o;
  logic [15:0] payload_index_o, payload_length_o;

  // parser copy
  parse_phase_e fr_phase = PhHunt;
  logic [7:0] head_cfg = 8'hab;
  logic [7:0] fr_src = '0, fr_dst = '0, fr_func = '0;
  logic [7:0] fr_sum = '0, fr_add = '0, fr_rx_sum = '0;
  logic [15:0] fr_len = '0, fr_count = '0;

  fpsac_pkg::result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned frame_bytes = 0;

  dir_row_t dir_tab [22] = '{
    '{8'hab, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h5a, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'h0c, 1'b0, 1'b1,
      '{fpsac_pkg::KindEnd, 8'h00, 16'h0000, 8'h00, 8'hff, 8'h5a, 16'h0000, 1'b1}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hab, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h3c, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hab, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'hab, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h5a, 1'b0, 1'b1,
      '{fpsac_pkg::KindEnd, 8'h00, 16'h0000, 8'hff, 8'h00, 8'hab, 16'h0002, 1'b0}},
    '{8'hab, 1'b0, 1'b0, '0}
  };

  frame_parser_sum_add_check i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_n),
    .head_byte_we_i        (head_we),
    .head_byte_i           (head_val),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready_o),
    .data_byte_i           (data_byte),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready),
    .kind_o                (kind_o),
    .payload_byte_o        (payload_byte_o),
    .payload_index_o       (payload_index_o),
    .source_address_o      (source_address_o),
    .destination_address_o (destination_address_o),
    .function_code_o       (function_code_o),
    .payload_length_o      (payload_length_o),
    .check_ok_o            (check_ok_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit parse_byte(input logic [7:0] b, output fpsac_pkg::result_t res);
    bit hit;
    bit acc;
    hit = 1'b0;
    acc = 1'b1;
    res = '0;
    case (fr_phase)
      PhSrc: begin
        fr_src = b;
        fr_phase = PhDst;
      end
      PhDst: begin
        fr_dst = b;
        fr_phase = PhFunc;
      end
      PhFunc: begin
        fr_func = b;
        fr_phase = PhLen1;
      end
      PhLen1: begin
        fr_len = {8'h00, b};
        fr_phase = PhLen2;
      end
      PhLen2: begin
        fr_len[15:8] = b;
        fr_count = '0;
        fr_phase = (fr_len == 16'd0) ? PhSum : PhData;
      end
      PhData: begin
        hit = 1'b1;
        res.kind = fpsac_pkg::KindPayload;
        res.payload_byte = b;
        res.payload_index = fr_count;
        fr_count = fr_count + 16'd1;
        if (fr_count == fr_len) fr_phase = PhSum;
      end
      PhSum: begin
        acc = 1'b0;
        fr_rx_sum = b;
        fr_phase = PhAdd;
      end
      PhAdd: begin
        acc = 1'b0;
        hit = 1'b1;
        res.kind = fpsac_pkg::KindEnd;
        res.check_ok = (fr_rx_sum == fr_sum) && (b == fr_add);
        fr_phase = PhHunt;
      end
      default: begin
        if (b == head_cfg) begin
          fr_sum = '0;
          fr_add = '0;
          fr_count = '0;
          fr_phase = PhSrc;
        end else begin
          acc = 1'b0;
          fr_phase = PhHunt;
        end
      end
    endcase
    if (acc) begin
      fr_sum = fr_sum + b;
      fr_add = fr_add + fr_sum;
    end
    res.source_address = fr_src;
    res.destination_address = fr_dst;
    res.function_code = fr_func;
    res.payload_length = fr_len;
    return hit;
  endfunction

  function automatic string fmt_result(input fpsac_pkg::result_t r);
    return $sformatf("kind %0d byte %02h index %0d src %02h dst %02h func %02h len %0d ok %0d",
                     r.kind, r.payload_byte, r.payload_index, r.source_address,
                     r.destination_address, r.function_code, r.payload_length,
                     r.check_ok);
  endfunction

  // called and returns at a falling edge
  task automatic put_byte(input logic [7:0] b, input bit typed,
                          input fpsac_pkg::result_t typed_res);
    fpsac_pkg::result_t res;
    bit hit;
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    hit = parse_byte(b, res);
    if (hit) pending_results.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic set_head(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    head_we <= 1'b1;
    head_val <= v;
    @(negedge clk_i);
    head_we <= 1'b0;
    head_cfg = v;
  endtask

  // check bytes are taken from the parser copy once the payload is in
  task automatic send_frame(input int unsigned plen, input bit corrupt, input int unsigned cut);
    logic [7:0] b;
    int unsigned total;
    int unsigned bad_pos;
    total = 8 + plen;
    bad_pos = 6 + plen + $urandom_range(1);
    for (int unsigned k = 0; k < total; k++) begin
      if (cut != 0 && k >= cut) break;
      if (k == 0) b = head_cfg;
      else if (k < 4) b = 8'($urandom_range(255));
      else if (k == 4) b = plen[7:0];
      else if (k == 5) b = plen[15:8];
      else if (k < 6 + plen) b = 8'($urandom_range(255));
      else if (k == 6 + plen) b = fr_sum;
      else b = fr_add;
      if (corrupt && k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      put_byte(b, 1'b0, '0);
      frame_bytes++;
    end
    // flush a cut-short frame back to the hunt
    while (fr_phase != PhHunt) put_byte(8'h00, 1'b0, '0);
  endtask

  always @(negedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 37);
  end

  always @(posedge clk_i) begin
    fpsac_pkg::result_t got;
    fpsac_pkg::result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      got = '{kind_o, payload_byte_o, payload_index_o, source_address_o,
              destination_address_o, function_code_o, payload_length_o, check_ok_o};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result beat: %s", fmt_result(got));
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.payload_index !== want.payload_index ||
            got.source_address !== want.source_address ||
            got.destination_address !== want.destination_address ||
            got.function_code !== want.function_code ||
            got.payload_length !== want.payload_length ||
            got.check_ok !== want.check_ok) begin
          if (mismatch_count < 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("frame_parser_sum_add_check test failed");
      $finish;
    end
  end

  initial begin
    int unsigned plen;
    int unsigned cut;
    logic [7:0] nb;
    repeat (4) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].head_write) begin
        set_head(dir_tab[i].value);
      end else begin
        put_byte(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_head(8'h00);
        1: set_head(8'hff);
        default: set_head(8'($urandom_range(255)));
      endcase
      calm = (p == 3);
      while (frame_bytes < (p + 1) * FrameTarget / NumPhases) begin
        repeat ($urandom_range(3)) begin
          do nb = 8'($urandom_range(255)); while (nb == head_cfg);
          put_byte(nb, 1'b0, '0);
        end
        plen = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(12);
        cut = ($urandom_range(19) == 0) ? $urandom_range(1, 7 + plen) : 0;
        send_frame(plen, $urandom_range(4) == 0, cut);
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("frame_parser_sum_add_check test passed");
    end else begin
      $display("frame_parser_sum_add_check test failed");
    end
    $finish;
  end

endmodule
